// ===== src/swhc_pkg.sv =====
package swhc_pkg;

  localparam int TS_BITS    = 31;
  localparam int HIT_BITS   = 8;
  localparam int TOTAL_BITS = 25;
  localparam int WIN_BITS   = 10;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = 10'd300;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE
  } state_t;

endpackage

// ===== src/sliding_window_hit_counter_top.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  timestamp, hit_count
// out       output     out_valid/out_ready  window_count, out_of_order, saturated
// cfg       input      cfg_write            cfg_data (window length)
//
// An item passes from IDLE to CHECK, stays in CHECK while buckets are popped
// from the front, then moves to UPDATE; the result is registered when UPDATE
// completes, and the next item is accepted only back in IDLE.
// CHECK reads one head entry of the bucket memory per cycle.
// Reset is synchronous; no clearing pass is run.
// A result waiting in the output register holds the current item in UPDATE.
module sliding_window_hit_counter_top #(
  parameter int DEPTH      = 512,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [swhc_pkg::WIN_BITS-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [swhc_pkg::TS_BITS-1:0]      timestamp,
  input  logic [swhc_pkg::HIT_BITS-1:0]     hit_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swhc_pkg::TOTAL_BITS-1:0]   window_count,
  output logic                              out_of_order,
  output logic                              saturated
);
  import swhc_pkg::*;

  localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UW      = $clog2(DEPTH + 1);
  localparam int ENTRY_W = TS_BITS + COUNT_BITS;
  localparam int AW      = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
  localparam logic [AW-1:0] COUNT_MAX = AW'((64'(1) << COUNT_BITS) - 64'(1));
  localparam logic [AW-1:0] TOTAL_MAX = AW'((64'(1) << TOTAL_BITS) - 64'(1));
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [UW-1:0] FULL_USED = UW'(DEPTH);

  state_t state, state_next;

  logic [WIN_BITS-1:0]   window_seconds;
  logic [TS_BITS-1:0]    ts_q;
  logic [HIT_BITS-1:0]   hit_q;
  logic [IW-1:0]         head_index, head_index_next;
  logic [IW-1:0]         tail_index, tail_index_next;
  logic [UW-1:0]         bucket_used, bucket_used_next;
  logic [TOTAL_BITS-1:0] running_total, running_total_next;
  logic [TS_BITS-1:0]    back_time, back_time_next;
  logic [COUNT_BITS-1:0] back_hits, back_hits_next;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we;
  logic [IW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [TS_BITS-1:0]    head_time;
  logic [COUNT_BITS-1:0] head_hits;
  logic [TS_BITS-1:0]    age;
  logic                  pop_age, pop_full, new_needed, do_pop;
  logic                  ooo, same, do_add, sat;
  logic [COUNT_BITS-1:0] base;
  logic [AW-1:0]         room_bucket, room_total, add;
  logic [COUNT_BITS-1:0] new_hits;
  logic [IW-1:0]         back_slot;
  logic                  in_fire, out_fire, upd_fire;

  assign head_time = rd_q[ENTRY_W-1 -: TS_BITS];
  assign head_hits = rd_q[COUNT_BITS-1:0];

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign upd_fire = (state == ST_UPDATE) && (!out_valid || out_ready);

  assign back_slot = (tail_index == '0) ? LAST_SLOT : tail_index - IW'(1);

  // Front eviction: a bucket goes when its age reaches the window, or when the
  // store is full and this item must open a new bucket.
  always_comb begin
    age        = ts_q - head_time;
    new_needed = (hit_q != '0) && ((bucket_used == '0) || (ts_q > back_time));
    pop_age    = (bucket_used != '0) && (ts_q >= head_time) &&
                 (age >= TS_BITS'(window_seconds));
    pop_full   = new_needed && (bucket_used == FULL_USED);
    do_pop     = (state == ST_CHECK) && (pop_age || pop_full);
  end

  // Back bucket update with clipping against the bucket and total maxima.
  always_comb begin
    ooo         = (bucket_used != '0) && (ts_q < back_time);
    same        = (bucket_used != '0) && (ts_q == back_time);
    do_add      = !ooo && (hit_q != '0);
    base        = same ? back_hits : '0;
    room_bucket = COUNT_MAX - AW'(base);
    room_total  = TOTAL_MAX - AW'(running_total);
    add         = do_add ? AW'(hit_q) : '0;
    sat         = 1'b0;
    if (add > room_bucket) begin
      add = room_bucket;
      sat = 1'b1;
    end
    if (add > room_total) begin
      add = room_total;
      sat = 1'b1;
    end
    new_hits = COUNT_BITS'(AW'(base) + add);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_CHECK;
      ST_CHECK:  if (!do_pop) state_next = ST_UPDATE;
      ST_UPDATE: if (upd_fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    head_index_next    = head_index;
    tail_index_next    = tail_index;
    bucket_used_next   = bucket_used;
    running_total_next = running_total;
    back_time_next     = back_time;
    back_hits_next     = back_hits;
    mem_we             = 1'b0;
    mem_addr           = tail_index;
    mem_wdata          = {ts_q, new_hits};
    if (do_pop) begin
      running_total_next = TOTAL_BITS'(AW'(running_total) - AW'(head_hits));
      head_index_next    = (head_index == LAST_SLOT) ? '0 : head_index + IW'(1);
      bucket_used_next   = bucket_used - UW'(1);
    end
    if (upd_fire && do_add) begin
      mem_we             = 1'b1;
      mem_addr           = same ? back_slot : tail_index;
      running_total_next = TOTAL_BITS'(AW'(running_total) + add);
      back_time_next     = ts_q;
      back_hits_next     = new_hits;
      if (!same) begin
        tail_index_next  = (tail_index == LAST_SLOT) ? '0 : tail_index + IW'(1);
        bucket_used_next = bucket_used + UW'(1);
      end
    end
  end

  // The head entry is read at its next address, so the data is ready in CHECK
  // the cycle after a pop. Writes happen only in UPDATE, so the head read that
  // is registered in IDLE for the next item already sees them.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[head_index_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      window_seconds <= WINDOW_RESET;
      head_index     <= '0;
      tail_index     <= '0;
      bucket_used    <= '0;
      running_total  <= '0;
      out_valid      <= 1'b0;
    end else begin
      state         <= state_next;
      head_index    <= head_index_next;
      tail_index    <= tail_index_next;
      bucket_used   <= bucket_used_next;
      running_total <= running_total_next;
      if (cfg_write) begin
        window_seconds <= cfg_data;
      end
      if (upd_fire) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    back_time <= back_time_next;
    back_hits <= back_hits_next;
    if (in_fire) begin
      ts_q  <= timestamp;
      hit_q <= hit_count;
    end
    if (upd_fire) begin
      window_count <= running_total_next;
      out_of_order <= ooo;
      saturated    <= sat;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    bucket_used <= FULL_USED)
    else $error("bucket count above store depth");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (bucket_used == '0) |-> (running_total == '0))
    else $error("total not zero with no live bucket");

  a_out_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_UPDATE))
    else $error("result raised outside the update step");

  a_update_grows: assert property (@(posedge clk) disable iff (rst)
    upd_fire |=> (running_total >= $past(running_total)))
    else $error("total dropped in the update step");

  a_no_write_in_check: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> !mem_we)
    else $error("bucket memory written during eviction");

endmodule
